FILE: sv/assert_macros.svh
// Assertion macros used by the set table RTL.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
// cond holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`endif
`endif

FILE: sv/ist_pkg.sv
// Types and codes of the integer set table.
// No dependencies.
`default_nettype none
package ist_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE
    } state_t;

    localparam int ELEM_W  = 32;
    localparam int TOTAL_W = 5;

    // control from sequencer to compare unit
    typedef struct packed {
        logic start;   // clear accumulators
        logic rd;      // a slot read is issued this cycle
    } scan_ctl_t;

    // compare unit summary
    typedef struct packed {
        logic hit;     // key found in a valid slot
        logic free;    // at least one free slot seen
    } scan_res_t;

endpackage
`default_nettype wire

FILE: sv/integer_set_table.sv
// Integer set table: add / remove / query on a bounded set of 32-bit values.
// Each operation scans every slot of the single-read-port slot RAM in turn (S_SCAN,
// S_LAST), then writes back in S_WRITE; the done strobe is registered from S_WRITE.
// One operation at a time: a new start is taken in the strobe cycle.
// Reset: after rst_n is released a clearing pass writes every slot invalid,
// with busy high. The receiver cannot stall the done strobe.
`default_nettype none
`include "assert_macros.svh"
module integer_set_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] elem,
    // result side
    output logic             done,
    output logic             success,
    output logic [1:0]       status,
    output logic [4:0]       member_total,
    output logic             is_empty
);
    import ist_pkg::*;

    // slot index width, and counter width that can also hold CAPACITY
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] LAST_SLOT = CW'(CAPACITY - 1);
    localparam int WORD_W = ELEM_W + 1;

    // sequencer state
    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;       // clear / scan slot pointer
    op_t           op_reg;
    logic [31:0]   elem_reg;
    logic [CW-1:0] count_reg, count_next;   // number of members

    // result beat registers
    logic          done_reg, done_next;
    logic          success_reg, success_next;
    status_t       status_reg, status_next;

    // RAM port controls
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [WORD_W-1:0] rd_data;

    scan_ctl_t         sctl;
    scan_res_t         sres;
    logic [IW-1:0]     hit_idx;
    logic [IW-1:0]     free_idx;
    logic              accept;

    assign accept = start && (state_reg == S_IDLE);

    ist_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .DW    (WORD_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    ist_scan #(
        .AW (IW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sctl),
        .rd_idx   (cnt_reg[IW-1:0]),
        .key      (elem_reg),
        .rd_data  (rd_data),
        .res      (sres),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // last slot read goes out this cycle
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:  state_next = S_WRITE;   // last compare lands
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cnt_next     = cnt_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        success_next = success_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = cnt_reg[IW-1:0];
        wr_data      = '0;
        rd_en        = 1'b0;
        sctl.start   = 1'b0;
        sctl.rd      = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                // invalidate one slot per cycle
                wr_en    = 1'b1;
                cnt_next = (cnt_reg == LAST_SLOT) ? '0 : cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                cnt_next   = '0;
                sctl.start = accept;
            end
            S_SCAN:
            begin
                rd_en    = 1'b1;
                sctl.rd  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            S_LAST:
            begin
                cnt_next = '0;
            end
            S_WRITE:
            begin
                done_next    = 1'b1;
                success_next = 1'b0;
                status_next  = ST_DONE;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        // duplicate check wins over full
                        if (sres.hit)
                        begin
                            status_next = ST_MISS;
                        end
                        else if (sres.free)
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = free_idx;
                            wr_data      = {1'b1, elem_reg};
                            count_next   = count_reg + 1'b1;
                            success_next = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (sres.hit)
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = hit_idx;
                            wr_data      = {1'b0, elem_reg};
                            count_next   = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                            success_next = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_MISS;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (sres.hit)
                        begin
                            success_next = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_MISS;
                        end
                    end
                    default:
                    begin
                        // unused code: report only
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            success_reg <= 1'b0;
            status_reg  <= ST_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            success_reg <= success_next;
            status_reg  <= status_next;
        end
    end

    // command beat capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(op);
            elem_reg <= elem;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign success      = success_reg;
    assign status       = status_reg;
    assign member_total = TOTAL_W'(count_reg);
    assign is_empty     = (count_reg == '0);

    // a result beat only follows the write-back cycle
    `ASSERT_IMPLY(a_done_after_write, clk, rst_n, done_reg, $past(state_reg == S_WRITE))
    // member count never passes capacity
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(CAPACITY))
    // a successful beat always carries status done
    `ASSERT_IMPLY(a_success_status, clk, rst_n, done_reg && success_reg, status_reg == ST_DONE)
    // count only moves in the write-back cycle
    `ASSERT_IMPLY(a_count_stable, clk, rst_n, state_reg != S_WRITE, count_next == count_reg)
    // RAM is never read and written in the same cycle
    `ASSERT_ALWAYS(a_port_excl, clk, rst_n, !(wr_en && rd_en))

endmodule
`default_nettype wire

FILE: sv/ist_mem.sv
// Slot memory: one word per slot, {valid, value}.
// Single write port, single read port, registered read data. No dependencies.
`default_nettype none
module ist_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 33
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/ist_scan.sv
// Compare unit: takes slot words one per cycle after the read latency,
// records first matching slot and lowest free slot. Uses ist_pkg.
`default_nettype none
module ist_scan #(
    parameter int AW = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ist_pkg::scan_ctl_t ctl,
    input  wire logic [AW-1:0]     rd_idx,
    input  wire logic [31:0]       key,
    input  wire logic [32:0]       rd_data,
    output ist_pkg::scan_res_t     res,
    output logic      [AW-1:0]     hit_idx,
    output logic      [AW-1:0]     free_idx
);
    import ist_pkg::*;

    logic          vld_d_reg;
    logic [AW-1:0] idx_d_reg;
    logic          hit_reg, hit_next;
    logic          free_reg, free_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic          slot_valid;
    logic [31:0]   slot_value;

    assign slot_valid = rd_data[32];
    assign slot_value = rd_data[31:0];

    always_comb
    begin
        hit_next      = hit_reg;
        free_next     = free_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        if (ctl.start)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
        else if (vld_d_reg)
        begin
            if (slot_valid && (slot_value == key) && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = idx_d_reg;
            end
            if (!slot_valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = idx_d_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            vld_d_reg <= ctl.rd;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_d_reg    <= rd_idx;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign res.hit  = hit_reg;
    assign res.free = free_reg;
    assign hit_idx  = hit_idx_reg;
    assign free_idx = free_idx_reg;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_set_table: directed and random add, remove,
// query and spare beats, checked against an in-bench set model. Needs ist_pkg.
module tb;
    import ist_pkg::*;

    // Must match the DUT default; the bench keeps its own copy of the slots.
    localparam int CAPACITY = 16;
    localparam int RANDOM_BEATS = 1750;
    // Worst case is about 1.8k beats, each a full operation plus a gap; leave room.
    localparam int CYCLE_LIMIT = 1000000;
    // Post-drain wait: one full operation plus margin catches a stray strobe.
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP = 100;
    // Unused op code: the block must leave the set alone and answer "done".
    localparam logic [1:0] OP_SPARE = 2'd3;

    // One result beat as the bench expects to see it.
    typedef struct packed {
        logic                success;
        status_t             status;
        logic [TOTAL_W-1:0]  total;
        logic                empty;
    } outcome_t;

    // One row of the directed stimulus. Rows with typed set carry their own
    // answer; the others are checked against the model.
    typedef struct {
        logic [1:0]          op;
        logic [ELEM_W-1:0]   elem;
        bit                  typed;
        outcome_t            res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          op;
    logic [ELEM_W-1:0]   elem;
    logic                done;
    logic                success;
    logic [1:0]          status;
    logic [TOTAL_W-1:0]  member_total;
    logic                is_empty;

    // Set model: slot contents, valid bits and member count.
    logic [ELEM_W-1:0]   held_value [CAPACITY];
    bit                  held_valid [CAPACITY];
    int                  held_count = 0;

    outcome_t            pending_results [$];
    int                  result_index = 0;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    bit                  no_idle_stretch = 1'b0;

    // Values that recur often so that duplicates, hits and removes happen.
    logic [ELEM_W-1:0]   hot_values [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000, 32'hA5A5_5A5A
    };

    integer_set_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .elem         (elem),
        .done         (done),
        .success      (success),
        .status       (status),
        .member_total (member_total),
        .is_empty     (is_empty)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t ns: result %0d: %s", $time, result_index, what);
    endtask

    // Apply one operation to the set model and return the beat it must give.
    // Duplicate beats full on add: the hit check comes first.
    function automatic outcome_t set_step(logic [1:0] beat_op, logic [ELEM_W-1:0] beat_elem);
        outcome_t r;
        int hit;
        int slot;
        hit = -1;
        slot = -1;
        r.success = 1'b0;
        r.status = ST_DONE;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit < 0 && held_valid[i] && held_value[i] == beat_elem)
                hit = i;
            if (slot < 0 && !held_valid[i])
                slot = i;
        end
        case (beat_op)
            OP_ADD:
            begin
                if (hit >= 0)
                    r.status = ST_MISS;
                else if (slot >= 0)
                begin
                    // lowest free slot takes the value
                    held_value[slot] = beat_elem;
                    held_valid[slot] = 1'b1;
                    held_count++;
                    r.success = 1'b1;
                end
                else
                    r.status = ST_FULL;
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    held_valid[hit] = 1'b0;
                    held_count--;
                    r.success = 1'b1;
                end
                else
                    r.status = ST_MISS;
            end
            OP_QUERY:
            begin
                if (hit >= 0)
                    r.success = 1'b1;
                else
                    r.status = ST_MISS;
            end
            default: ;   // spare code: nothing changes
        endcase
        r.total = TOTAL_W'(held_count);
        r.empty = (held_count == 0);
        return r;
    endfunction

    // Operand for a random beat. Removes and queries mostly aim at members,
    // adds mix duplicates, hot values and fresh 32-bit patterns.
    function automatic logic [ELEM_W-1:0] pick_operand(logic [1:0] beat_op);
        int members [$];
        int src;
        for (int i = 0; i < CAPACITY; i++)
            if (held_valid[i])
                members.push_back(i);
        src = $urandom_range(0, 99);
        if (src < (beat_op == OP_ADD ? 25 : 60) && members.size() > 0)
            return held_value[members[$urandom_range(0, members.size() - 1)]];
        if (src < (beat_op == OP_ADD ? 60 : 80))
            return hot_values[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic dir_row_t row(logic [1:0] o, logic [ELEM_W-1:0] e, bit t,
                                     logic s, status_t st, int tot, logic emp);
        dir_row_t r;
        r.op = o;
        r.elem = e;
        r.typed = t;
        r.res.success = s;
        r.res.status = st;
        r.res.total = TOTAL_W'(tot);
        r.res.empty = emp;
        return r;
    endfunction

    // Present one command beat at the falling edge and hold it until a rising
    // edge sees busy low. start stays high afterwards; the next call or a gap
    // decides at the following falling edge.
    task automatic send_beat(logic [1:0] beat_op, logic [ELEM_W-1:0] beat_elem,
                             bit typed, outcome_t typed_res);
        outcome_t predicted;
        @(negedge clk);
        start <= 1'b1;
        op    <= beat_op;
        elem  <= beat_elem;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // accepted at this edge: advance the model in acceptance order
        predicted = set_step(beat_op, beat_elem);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Random gap on the command side: mostly none or short, now and then long.
    // Gap lengths span a whole operation so new starts land in every phase.
    task automatic idle_gap();
        int n;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle_stretch || pick < 55)
            n = 0;
        else if (pick < 85)
            n = $urandom_range(1, 3);
        else if (pick < 97)
            n = $urandom_range(4, 24);
        else
            n = $urandom_range(30, 80);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            op    <= 2'($urandom);   // junk on the bus while idle
            elem  <= $urandom;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drop start and hold off until every outstanding beat has come back.
    task automatic drain_pending();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Result side: the strobe cannot be stalled, so every done beat is taken.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (success !== want.success)
                    report_mismatch($sformatf("ok flag got %0d want %0d",
                                              success, want.success));
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.status));
                if (member_total !== want.total)
                    report_mismatch($sformatf("member_total got %0d want %0d",
                                              member_total, want.total));
                if (is_empty !== want.empty)
                    report_mismatch($sformatf("is_empty got %0d want %0d",
                                              is_empty, want.empty));
            end
            result_index++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            report_mismatch($sformatf("timeout, %0d results outstanding",
                                      pending_results.size()));
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        dir_row_t          dir_rows [$];
        logic [1:0]        beat_op;
        logic [ELEM_W-1:0] beat_elem;
        int                pick;
        bit                growing;

        for (int i = 0; i < CAPACITY; i++)
        begin
            held_value[i] = '0;
            held_valid[i] = 1'b0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        op    = OP_ADD;
        elem  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // The clearing pass after reset shows up as busy; send_beat waits it out.

        // Directed part: empty table, field extremes, every op code, the
        // duplicate check, refill to capacity, then full and duplicate-on-full.
        dir_rows.push_back(row(OP_QUERY,  32'h0000_0000, 1, 0, ST_MISS, 0, 1));
        dir_rows.push_back(row(OP_REMOVE, 32'h0000_0005, 1, 0, ST_MISS, 0, 1));
        dir_rows.push_back(row(OP_SPARE,  32'h0000_0007, 1, 0, ST_DONE, 0, 1));
        dir_rows.push_back(row(OP_ADD,    32'h8000_0000, 1, 1, ST_DONE, 1, 0));
        dir_rows.push_back(row(OP_ADD,    32'h7FFF_FFFF, 1, 1, ST_DONE, 2, 0));
        dir_rows.push_back(row(OP_ADD,    32'hFFFF_FFFF, 1, 1, ST_DONE, 3, 0));
        dir_rows.push_back(row(OP_ADD,    32'h0000_0000, 1, 1, ST_DONE, 4, 0));
        dir_rows.push_back(row(OP_ADD,    32'h8000_0000, 1, 0, ST_MISS, 4, 0));
        dir_rows.push_back(row(OP_QUERY,  32'h7FFF_FFFF, 1, 1, ST_DONE, 4, 0));
        dir_rows.push_back(row(OP_REMOVE, 32'h7FFF_FFFF, 1, 1, ST_DONE, 3, 0));
        dir_rows.push_back(row(OP_QUERY,  32'h7FFF_FFFF, 1, 0, ST_MISS, 3, 0));
        dir_rows.push_back(row(OP_SPARE,  32'hFFFF_FFFF, 1, 0, ST_DONE, 3, 0));
        // refill the freed slot and the rest: 3 -> 16 members
        for (int k = 0; k < CAPACITY - 3; k++)
            dir_rows.push_back(row(OP_ADD, 32'h1 << (2 * k + 1), 0, 0, ST_DONE, 0, 0));
        dir_rows.push_back(row(OP_ADD,    32'h1234_5678, 1, 0, ST_FULL, 16, 0));
        // already present in a full table: duplicate wins over full
        dir_rows.push_back(row(OP_ADD,    32'h0000_0000, 1, 0, ST_MISS, 16, 0));

        foreach (dir_rows[r])
        begin
            send_beat(dir_rows[r].op, dir_rows[r].elem, dir_rows[r].typed, dir_rows[r].res);
            idle_gap();
        end
        drain_pending();

        // Random part: alternate growing and shrinking phases so the table
        // swings between empty and full many times.
        growing = 1'b0;
        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k % 150 == 0)
                no_idle_stretch = ($urandom_range(0, 3) == 0);
            if (k % 400 == 200)
                drain_pending();
            if (growing && held_count == CAPACITY && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (!growing && held_count == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                beat_op = OP_SPARE;
            else if (pick < 25)
                beat_op = OP_QUERY;
            else if (pick < (growing ? 85 : 40))
                beat_op = OP_ADD;
            else
                beat_op = OP_REMOVE;
            beat_elem = pick_operand(beat_op);
            send_beat(beat_op, beat_elem, 1'b0, '0);
            idle_gap();
        end

        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
